>>> rtl/dlzss_pkg.sv
// Shared types, constants and descramble helpers for the descramble LZSS decoder.
`default_nettype none

package dlzss_pkg;

	localparam int unsigned WIN_DEPTH = 2048;
	localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);

	localparam logic [WIN_AW-1:0] START_POS = 11'h7df;
	localparam logic [WIN_AW-1:0] LAST_POS  = 11'h7ff;
	localparam logic [7:0]        SCR_BIAS  = 8'h7c;
	localparam logic [5:0]        MIN_LEN   = 6'd2;
	localparam logic [8:0]        TOK_MARK  = 9'h100;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LIT,
		PH_OFS,
		PH_LEN
	} phase_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic copy_en;
		logic next_tok;
		logic clear_en;
	} dp_cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   out_free;
		logic   copy_done;
		logic   clear_done;
		logic   last;
	} dp_sts_t;

	// ((key >> 24) + (key >> 3)) mod 256
	function automatic logic [7:0] key_byte(input logic [31:0] key);
		return key[31:24] + key[10:3];
	endfunction

	// ((key >> 20) mod 5) + 1; 16 = 1 mod 5, so fold nibbles twice
	function automatic logic [2:0] rot_amt(input logic [31:0] key);
		logic [5:0] s;
		logic [4:0] t;
		logic [4:0] r;
		s = {2'b00, key[31:28]} + {2'b00, key[27:24]} + {2'b00, key[23:20]};
		t = {3'b000, s[5:4]} + {1'b0, s[3:0]};
		if (t >= 5'd15) begin
			r = t - 5'd15;
		end else if (t >= 5'd10) begin
			r = t - 5'd10;
		end else if (t >= 5'd5) begin
			r = t - 5'd5;
		end else begin
			r = t;
		end
		return r[2:0] + 3'd1;
	endfunction

	function automatic logic [7:0] descramble(input logic [7:0] b, input logic [7:0] kb,
			input logic [2:0] rot);
		logic [7:0]  t;
		logic [15:0] w;
		t = (b - SCR_BIAS) ^ kb;
		w = {t, t} >> rot;
		return w[7:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/dlzss_ctrl.sv
// Control state machine: sequences accept, execute, match copy and window clear.
`default_nettype none

module dlzss_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  dlzss_pkg::dp_sts_t   sts,
	output dlzss_pkg::dp_cmd_t   cmd
);
	import dlzss_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        exec_ok;

	// a literal needs the output slot free before it executes
	assign exec_ok = (sts.phase != PH_LIT) || sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_ok) begin
					if (sts.phase == PH_LEN) begin
						state_nxt = ST_COPY;
					end else if (sts.last) begin
						state_nxt = ST_CLEAR;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_COPY: begin
				if (sts.copy_done) begin
					state_nxt = sts.last ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = exec_ok;
			end
			ST_COPY: begin
				cmd.copy_en  = 1'b1;
				cmd.next_tok = sts.copy_done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/dlzss_dp.sv
// Datapath: key registers, descrambler, parser state, window memory, copy pipe, output register.
`default_nettype none

module dlzss_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wr_en,
	input  wire  [31:0]          cfg_wr_data,
	input  wire  [7:0]           in_byte,
	input  wire                  in_last,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  dlzss_pkg::dp_cmd_t   cmd,
	output dlzss_pkg::dp_sts_t   sts
);
	import dlzss_pkg::*;

	logic [7:0]        key_byte_q;
	logic [2:0]        rot_q;
	logic [7:0]        in_byte_q;
	logic              last_q;
	logic [7:0]        d;

	logic [8:0]        token_q;
	phase_t            phase_q;
	logic [7:0]        ofs_low_q;
	logic [8:0]        tok_sh;
	phase_t            ph_nt;

	logic [7:0]        mem [WIN_DEPTH];
	logic [WIN_AW-1:0] wp_q;
	logic [WIN_AW-1:0] clr_cnt_q;
	logic              clr_end;
	logic              mem_we;
	logic [WIN_AW-1:0] mem_waddr;
	logic [7:0]        mem_wdata;

	logic [WIN_AW-1:0] rd_addr_q;
	logic [5:0]        remain_q;
	logic              pend_s1;
	logic [7:0]        rdata_s1;
	logic              fwd_s1;
	logic [7:0]        fwd_byte_s1;
	logic [7:0]        copy_byte;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_free;
	logic              lit_wr;
	logic              copy_adv;
	logic              copy_wr;
	logic              copy_rd;

	// key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_byte_q <= key_byte('0);
			rot_q      <= rot_amt('0);
		end else if (cfg_wr_en) begin
			key_byte_q <= key_byte(cfg_wr_data);
			rot_q      <= rot_amt(cfg_wr_data);
		end
	end

	// input beat
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_byte_q <= in_byte;
			last_q    <= in_last;
		end
	end

	assign d = descramble(in_byte_q, key_byte_q, rot_q);

	assign tok_sh = {1'b0, token_q[8:1]};
	assign ph_nt  = (tok_sh <= 9'd1) ? PH_FLAG : (tok_sh[0] ? PH_LIT : PH_OFS);

	assign clr_end  = cmd.clear_en && (clr_cnt_q == LAST_POS);
	assign out_free = !out_valid_q || out_ready;
	assign lit_wr   = cmd.exec && (phase_q == PH_LIT);
	assign copy_adv = cmd.copy_en && (!pend_s1 || out_free);
	assign copy_wr  = copy_adv && pend_s1;
	assign copy_rd  = copy_adv && (remain_q != '0);
	assign copy_byte = fwd_s1 ? fwd_byte_s1 : rdata_s1;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q   <= '0;
			phase_q   <= PH_FLAG;
			ofs_low_q <= '0;
		end else if (clr_end) begin
			token_q   <= '0;
			phase_q   <= PH_FLAG;
			ofs_low_q <= '0;
		end else if (cmd.exec) begin
			case (phase_q)
				PH_FLAG: begin
					token_q <= TOK_MARK | {1'b0, d};
					phase_q <= d[0] ? PH_LIT : PH_OFS;
				end
				PH_LIT: begin
					token_q <= tok_sh;
					phase_q <= ph_nt;
				end
				PH_OFS: begin
					ofs_low_q <= d;
					phase_q   <= PH_LEN;
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end else if (cmd.next_tok) begin
			token_q <= tok_sh;
			phase_q <= ph_nt;
		end
	end

	// write position and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= START_POS;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clear_en) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (clr_end) begin
				wp_q <= START_POS;
			end else if (lit_wr || copy_wr) begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	assign mem_we    = cmd.clear_en || lit_wr || copy_wr;
	assign mem_waddr = cmd.clear_en ? clr_cnt_q : wp_q;
	assign mem_wdata = cmd.clear_en ? 8'h00 : (lit_wr ? d : copy_byte);

	// window memory, read-old-data; same-cycle collision handled by forwarding
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (copy_rd) begin
			rdata_s1 <= mem[rd_addr_q];
		end
	end

	// copy pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			pend_s1  <= 1'b0;
		end else if (cmd.exec && (phase_q == PH_LEN)) begin
			remain_q <= {1'b0, d[4:0]} + MIN_LEN;
			pend_s1  <= 1'b0;
		end else if (copy_adv) begin
			if (remain_q != '0) begin
				remain_q <= remain_q - 1'b1;
				pend_s1  <= 1'b1;
			end else begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (phase_q == PH_LEN)) begin
			rd_addr_q <= {d[7:5], ofs_low_q};
		end else if (copy_rd) begin
			rd_addr_q   <= rd_addr_q + 1'b1;
			fwd_s1      <= pend_s1 && (rd_addr_q == wp_q);
			fwd_byte_s1 <= copy_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (lit_wr || copy_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lit_wr) begin
			out_byte_q <= d;
			out_last_q <= 1'b1;
		end else if (copy_wr) begin
			out_byte_q <= copy_byte;
			out_last_q <= (remain_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	assign sts.phase      = phase_q;
	assign sts.out_free   = out_free;
	assign sts.copy_done  = (remain_q == '0) && !pend_s1;
	assign sts.clear_done = clr_end;
	assign sts.last       = last_q;

endmodule

`default_nettype wire

>>> rtl/descramble_lzss_decoder_core.sv
// Top level of the descramble LZSS decoder: controller plus datapath.
//
//  channel  | direction | beat fields (tdata low bit up)   | marker
//  s_axis   | in        | in_byte[7:0]                     | tlast = last_byte
//  m_axis   | out       | out_byte[7:0]                    | tlast = run_last
//  cfg      | in        | cfg_wr_data = file_key[31:0]     | cfg_wr_en, no ready
//
// Flag, offset and literal beats go through accept and then execute.
// A match adds a copy loop that moves one byte per cycle while m_axis is not stalled,
// through the single-port-write window memory with a registered read.
// Reset and the end of every stream (tlast) start a clearing pass over all 2048
// window entries, one entry a cycle; no input beat is taken during it.
// A stalled m_axis freezes the copy pipe; s_axis is held off until the item is done.
`default_nettype none

module descramble_lzss_decoder_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [31:0] cfg_wr_data,    // file_key
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // in_byte
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte
	output logic        m_axis_tlast
);
	import dlzss_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	dlzss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dlzss_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.out_byte    (m_axis_tdata),
		.out_last    (m_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire

>>> rtl/dlzss_chk.sv
// Port-level checker for the descramble LZSS decoder, bound to the top level.
`default_nettype none

module dlzss_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        s_axis_tlast,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [7:0]  m_axis_tdata,
	input wire        m_axis_tlast
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed under stall");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while previous item in work");

	// end of stream starts the window clear
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=>
			!s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
		else $error("input taken too soon after end of stream");

	// nothing comes out and no input is taken in the cycle right after reset release
	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid && !s_axis_tready)
		else $error("activity right after reset");

endmodule

bind descramble_lzss_decoder_core dlzss_chk u_chk (.*);

`default_nettype wire

>>> bench/tb_descramble_lzss_decoder_core.sv
// Self-checking bench for the descramble LZSS decoder core: directed table, then random streams.
`default_nettype none

module tb_descramble_lzss_decoder_core;
	import dlzss_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;  // run watchdog
	localparam int DRAIN_CAP   = 20_000;     // per drain; covers a clear pass and the long hold
	localparam int LONG_HOLD   = 400;        // receiver hold-off, in cycles
	localparam int PHASE_BEATS = 48;         // random input beats per key setting
	localparam int N_PHASES    = 6;
	localparam int N_DIR       = 20;
	localparam int PRINT_CAP   = 40;

	// one output beat: decoded byte plus the end-of-item marker
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	// one input beat ready to drive (already scrambled)
	typedef struct packed {
		logic [7:0] raw;
		logic       last;
	} in_beat_t;

	// directed row: plain token byte, tlast, and a typed expectation where obvious
	typedef struct packed {
		logic [7:0] plain;
		logic       last;
		logic       typed;   // 1: expect n_res copies of val instead of the predictor
		logic [5:0] n_res;
		logic [7:0] val;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;

	descramble_lzss_decoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),    // file_key
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // in_byte[7:0]
		.s_axis_tlast  (s_axis_tlast),   // last_byte
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // out_byte[7:0]
		.m_axis_tlast  (m_axis_tlast)    // run_last
	);

	// ---------------------------------------------------------------------
	// Decoder shadow state: window copy, write pointer, token bits, phase
	// ---------------------------------------------------------------------
	logic [7:0]  win_copy [0:WIN_DEPTH-1];
	logic [10:0] wr_ptr;
	logic [8:0]  tok_bits;
	phase_t      parse_ph;
	logic [7:0]  ofs_lo;
	logic [31:0] key_shadow;

	out_beat_t   step_out[$];      // output beats of the beat being decoded
	out_beat_t   pending_out[$];   // expected output beats, oldest first
	in_beat_t    stim_q[$];        // stream under construction

	int  cycle_cnt = 0;
	int  mismatch_cnt;
	int  beats_in;
	int  beats_out;
	int  n_streams;
	int  n_keys;
	bit  quiet;       // no idling on either side
	bit  long_hold;   // request for the long receiver hold-off

	// ---------------------------------------------------------------------
	// Clock and watchdog
	// ---------------------------------------------------------------------
	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Byte scrambling, both directions
	// ---------------------------------------------------------------------
	// received byte -> token byte: subtract bias, xor key byte, rotate right
	function automatic logic [7:0] desc_byte(input logic [7:0] raw, input logic [31:0] key);
		logic [7:0]  kb;
		logic [7:0]  t;
		int unsigned rot;
		kb  = 8'((key >> 24) + (key >> 3));
		rot = (key >> 20) % 5 + 1;
		t   = (raw - 8'h7c) ^ kb;
		return (t >> rot) | (t << (8 - rot));
	endfunction

	// inverse, used only to build well-formed streams
	function automatic logic [7:0] scr_byte(input logic [7:0] plain, input logic [31:0] key);
		logic [7:0]  kb;
		logic [7:0]  t;
		int unsigned rot;
		kb  = 8'((key >> 24) + (key >> 3));
		rot = (key >> 20) % 5 + 1;
		t   = (plain << rot) | (plain >> (8 - rot));
		return (t ^ kb) + 8'h7c;
	endfunction

	// ---------------------------------------------------------------------
	// Decoder prediction
	// ---------------------------------------------------------------------
	task automatic clear_window();
		for (int i = 0; i < WIN_DEPTH; i++)
			win_copy[i] = 8'h00;
		wr_ptr   = START_POS;
		tok_bits = '0;
		parse_ph = PH_FLAG;
		ofs_lo   = '0;
	endtask

	// every decoded byte also goes back into the window
	task automatic put_byte(input logic [7:0] v);
		win_copy[wr_ptr] = v;
		wr_ptr = wr_ptr + 11'd1;
		step_out.push_back('{data: v, last: 1'b0});
	endtask

	// shift to the next token bit; marker at bit 0 means a new flag byte is due
	task automatic next_token();
		tok_bits = tok_bits >> 1;
		if (tok_bits <= 9'd1)
			parse_ph = PH_FLAG;
		else
			parse_ph = tok_bits[0] ? PH_LIT : PH_OFS;
	endtask

	// decode one accepted input beat into step_out
	task automatic decode_step(input logic [7:0] raw, input logic last);
		logic [7:0]  d;
		logic [10:0] src;
		int          cnt;
		out_beat_t   tail;
		d = desc_byte(raw, key_shadow);
		step_out.delete();
		case (parse_ph)
			PH_FLAG: begin
				tok_bits = {1'b1, d};
				parse_ph = d[0] ? PH_LIT : PH_OFS;
			end
			PH_LIT: begin
				put_byte(d);
				next_token();
			end
			PH_OFS: begin
				ofs_lo   = d;
				parse_ph = PH_LEN;
			end
			default: begin
				// byte-wise copy, so a source just behind wr_ptr repeats bytes
				src = {d[7:5], ofs_lo};
				cnt = d[4:0] + 2;
				for (int i = 0; i < cnt; i++) begin
					put_byte(win_copy[src]);
					src = src + 11'd1;
				end
				next_token();
			end
		endcase
		if (step_out.size() > 0) begin
			tail = step_out.pop_back();
			tail.last = 1'b1;
			step_out.push_back(tail);
		end
		if (last)
			clear_window();
	endtask

	// ---------------------------------------------------------------------
	// Mismatch reporting
	// ---------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_CAP)
			$display("cycle %0d: %s", cycle_cnt, msg);
	endtask

	// ---------------------------------------------------------------------
	// Output monitor: each m_axis beat against the oldest expectation
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : out_check
		out_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_out++;
			if (pending_out.size() == 0) begin
				report_mismatch($sformatf("unexpected output beat data=%02h last=%0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = pending_out.pop_front();
				if (m_axis_tdata !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						m_axis_tdata, want.data));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("run_last %0b, expected %0b (byte %02h)",
						m_axis_tlast, want.last, want.data));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random ready bursts, plus one long hold-off on request
	// ---------------------------------------------------------------------
	initial begin : sink
		int hold_cycles;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
					@(negedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------------
	// Entered and left at a falling edge. Predicts on acceptance; typed rows
	// replace the predictor's beats with n copies of val.
	task automatic send_beat(input logic [7:0] raw, input logic last, input logic typed,
			input int n, input logic [7:0] val);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tdata  <= raw;
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		beats_in++;
		decode_step(raw, last);
		if (typed) begin
			for (int k = 0; k < n; k++)
				pending_out.push_back('{data: val, last: (k == n - 1)});
		end else begin
			foreach (step_out[k])
				pending_out.push_back(step_out[k]);
		end
		@(negedge clk);
	endtask

	// stop offering, wait for every expected beat, then a short settle
	task automatic wait_drained();
		int waited;
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending_out.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_key(input logic [31:0] k);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= k;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		key_shadow = k;
		n_keys++;
	endtask

	// Build one stream into stim_q. Mostly well-formed token groups with random
	// content and matches aimed at recent output; some raw noise and some
	// streams cut mid-token. The last beat always carries tlast.
	task automatic build_stream();
		int          mode;
		int          groups;
		int          made;
		int          back_dist;
		int          cut;
		logic [7:0]  flag;
		logic [10:0] gpos;
		logic [10:0] ofs;
		logic [4:0]  lenf;
		in_beat_t    tail;
		stim_q.delete();
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			repeat ($urandom_range(1, 24))
				stim_q.push_back('{raw: 8'($urandom), last: 1'b0});
		end else begin
			gpos   = START_POS;
			made   = 0;
			groups = $urandom_range(1, 4);
			repeat (groups) begin
				flag = 8'($urandom);
				stim_q.push_back('{raw: scr_byte(flag, key_shadow), last: 1'b0});
				for (int b = 0; b < 8; b++) begin
					if (flag[b]) begin
						stim_q.push_back('{raw: scr_byte(8'($urandom), key_shadow),
							last: 1'b0});
						gpos = gpos + 11'd1;
						made++;
					end else begin
						if (made > 0 && $urandom_range(0, 3) != 0) begin
							back_dist = $urandom_range(1, (made < 64) ? made : 64);
							ofs       = gpos - 11'(back_dist);
						end else begin
							ofs = 11'($urandom);
						end
						case ($urandom_range(0, 9))
							0:       lenf = 5'h1f;
							1:       lenf = 5'($urandom);
							default: lenf = 5'($urandom_range(0, 5));
						endcase
						stim_q.push_back('{raw: scr_byte(ofs[7:0], key_shadow),
							last: 1'b0});
						stim_q.push_back('{raw: scr_byte({ofs[10:8], lenf}, key_shadow),
							last: 1'b0});
						gpos = gpos + 11'(lenf) + 11'd2;
						made = made + lenf + 2;
					end
				end
			end
			// broken stream: end it at an arbitrary point, often mid-token
			if (mode == 1) begin
				cut = $urandom_range(1, stim_q.size());
				while (stim_q.size() > cut)
					void'(stim_q.pop_back());
			end
		end
		tail = stim_q.pop_back();
		tail.last = 1'b1;
		stim_q.push_back(tail);
	endtask

	// ---------------------------------------------------------------------
	// Directed table, decoded under key 0 right after reset.
	// Window is zero, write pointer at the start position.
	// ---------------------------------------------------------------------
	dir_row_t dir_tab [0:N_DIR-1];

	initial begin
		dir_tab = '{
			// flag 0x0f: four literals, then four matches
			'{8'h0f, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'h00, 1'b0, 1'b1, 6'd1,  8'h00},
			'{8'hff, 1'b0, 1'b1, 6'd1,  8'hff},
			'{8'h80, 1'b0, 1'b1, 6'd1,  8'h80},
			'{8'h55, 1'b0, 1'b1, 6'd1,  8'h55},
			// shortest match from the untouched zero window
			'{8'h00, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'h00, 1'b0, 1'b1, 6'd2,  8'h00},
			// longest match at the top offset, wraps around the window
			'{8'hff, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'hff, 1'b0, 1'b1, 6'd33, 8'h00},
			// copy the four literals back from the start position
			'{8'hdf, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'he2, 1'b0, 1'b0, 6'd0,  8'h00},
			// source one behind the write pointer: overlapping copy repeats
			'{8'h09, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'h03, 1'b0, 1'b0, 6'd0,  8'h00},
			// stream ends on a flag byte
			'{8'hfe, 1'b1, 1'b1, 6'd0,  8'h00},
			// stream ends between offset and length: token dropped
			'{8'hfe, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'h12, 1'b1, 1'b1, 6'd0,  8'h00},
			// fresh stream: literal then a match over what the first
			// stream wrote, which must read back as zero after the clear
			'{8'h01, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'h3c, 1'b0, 1'b1, 6'd1,  8'h3c},
			'{8'h06, 1'b0, 1'b1, 6'd0,  8'h00},
			'{8'h01, 1'b1, 1'b1, 6'd3,  8'h00}
		};
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : main
		int         phase_beats;
		logic [31:0] k;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		mismatch_cnt  = 0;
		beats_in      = 0;
		beats_out     = 0;
		n_streams     = 0;
		n_keys        = 0;
		quiet         = 1'b0;
		long_hold     = 1'b0;
		key_shadow    = '0;
		clear_window();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// key 0 is the reset value; written anyway so the register sees a write
		write_key(32'h0000_0000);
		for (int r = 0; r < N_DIR; r++)
			send_beat(scr_byte(dir_tab[r].plain, key_shadow), dir_tab[r].last,
				dir_tab[r].typed, dir_tab[r].n_res, dir_tab[r].val);
		n_streams += 3;

		// random phases, one key each; key written only with the block drained
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0:       k = 32'hffff_ffff;
				2:       k = 32'h0040_0000;   // largest rotate, zero key byte
				4:       k = 32'h0000_0000;
				default: k = $urandom;
			endcase
			write_key(k);
			quiet = (ph == N_PHASES - 1);
			// receiver goes quiet for a long stretch while beats keep coming
			if (ph == 2)
				long_hold = 1'b1;
			phase_beats = 0;
			while (phase_beats < PHASE_BEATS) begin
				build_stream();
				n_streams++;
				foreach (stim_q[i]) begin
					send_beat(stim_q[i].raw, stim_q[i].last, 1'b0, 0, 8'h00);
					phase_beats++;
				end
			end
		end

		wait_drained();
		repeat (24) @(posedge clk);
		if (pending_out.size() != 0)
			report_mismatch($sformatf("%0d expected output beats never arrived",
				pending_out.size()));

		$display("run covered %0d streams under %0d key settings", n_streams, n_keys);
		$display("%0d input beats sent, %0d output beats checked", beats_in, beats_out);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
